// File: hdl/tsad_pkg.sv
// Shared widths, register map, state types and sizing helpers for the averaging decimator.
package tsad_pkg;

    localparam int TIME_W        = 48;
    localparam int VALUE_W       = 32;
    localparam int GSIZE_W       = 11;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam int DEF_MAX_GROUP = 1024;

    localparam logic [ADDR_W-1:0] ADDR_GROUP_SIZE = 3'd0;
    localparam logic [GSIZE_W-1:0] GSIZE_RESET    = 11'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_START_TIME,
        ST_WAIT_TIME,
        ST_START_VALUE,
        ST_WAIT_VALUE,
        ST_EMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_RUN,
        DS_SIGN
    } div_state_t;

    typedef struct packed {
        logic start;
        logic sel_value;
    } div_ctrl_t;

    function automatic int count_width(input int max_group);
        return $clog2(max_group + 1);
    endfunction

    function automatic int sum_width(input int max_group);
        return TIME_W + 1 + $clog2(max_group);
    endfunction

endpackage

// File: hdl/tsad_div.sv
// Shared signed-by-unsigned restoring divider, one quotient bit per cycle, truncating toward zero.
module tsad_div #(
    parameter int NUM_W = 59,
    parameter int DEN_W = 11
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0]        divisor,
    output logic                    done,
    output logic signed [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    tsad_pkg::div_state_t state_reg;
    tsad_pkg::div_state_t state_next;

    logic [NUM_W-1:0] acc_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [NUM_W-1:0] quot_reg;

    logic [NUM_W-1:0] mag;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] acc_next;

    always_comb
    begin
        mag   = dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
        trial = {rem_reg, acc_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        acc_next = {acc_reg[NUM_W-2:0], fits};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsad_pkg::DS_IDLE:
            begin
                if (start)
                begin
                    state_next = tsad_pkg::DS_RUN;
                end
            end
            tsad_pkg::DS_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = tsad_pkg::DS_SIGN;
                end
            end
            tsad_pkg::DS_SIGN:
            begin
                state_next = tsad_pkg::DS_IDLE;
            end
            default:
            begin
                state_next = tsad_pkg::DS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsad_pkg::DS_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == tsad_pkg::DS_SIGN);
            if (state_reg == tsad_pkg::DS_IDLE && start)
            begin
                cnt_reg <= CNT_W'(NUM_W - 1);
            end
            else if (state_reg == tsad_pkg::DS_RUN)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            tsad_pkg::DS_IDLE:
            begin
                if (start)
                begin
                    acc_reg <= mag;
                    rem_reg <= '0;
                    den_reg <= divisor;
                    neg_reg <= dividend[NUM_W-1];
                end
            end
            tsad_pkg::DS_RUN:
            begin
                acc_reg <= acc_next;
                rem_reg <= rem_next;
            end
            tsad_pkg::DS_SIGN:
            begin
                quot_reg <= neg_reg ? (~acc_reg + 1'b1) : acc_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// File: hdl/time_series_average_decimator.sv
// Averaging decimator top level: accumulators, group sequencer, APB register and result register.
// An accepted word that does not close a group passes through ST_ACCUM and back to idle. A word
// that closes a group also runs the shared restoring divider, which yields one quotient bit per
// cycle, first for the mean time offset (SUM_W = 49 + clog2(MAX_GROUP), 59 by default) and, when
// the group held a valid sample, again for the mean value, before ST_EMIT loads the output
// register. The load waits while an earlier result is still unaccepted. smp_ready is high only
// while the sequencer is idle. The finished result sits in an output register, so the next word
// is taken while that result waits for res_ready.
module time_series_average_decimator #(
    parameter int MAX_GROUP = tsad_pkg::DEF_MAX_GROUP
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tsad_pkg::ADDR_W-1:0]         paddr,
    input  logic [tsad_pkg::DATA_W-1:0]         pwdata,
    output logic [tsad_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                smp_valid,
    output logic                                smp_ready,
    input  logic [tsad_pkg::TIME_W-1:0]         sample_time,
    input  logic                                sample_valid,
    input  logic signed [tsad_pkg::VALUE_W-1:0] sample_value,
    input  logic                                end_of_range,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [tsad_pkg::TIME_W-1:0]         avg_time,
    output logic                                avg_valid,
    output logic signed [tsad_pkg::VALUE_W-1:0] avg_value,
    output logic                                is_last
);

    localparam int CNT_W = tsad_pkg::count_width(MAX_GROUP);
    localparam int SUM_W = tsad_pkg::sum_width(MAX_GROUP);
    localparam int TW    = tsad_pkg::TIME_W;
    localparam int VW    = tsad_pkg::VALUE_W;
    localparam int GW    = tsad_pkg::GSIZE_W;
    localparam int EW    = (CNT_W > GW) ? CNT_W : GW;

    tsad_pkg::seq_state_t state_reg;
    tsad_pkg::seq_state_t state_next;
    tsad_pkg::div_ctrl_t  div_ctrl;

    logic [GW-1:0]            group_size_reg;
    logic [TW-1:0]            start_time_reg;
    logic signed [SUM_W-1:0]  offset_sum_reg;
    logic signed [SUM_W-1:0]  value_sum_reg;
    logic [CNT_W-1:0]         valid_count_reg;
    logic [CNT_W-1:0]         sample_count_reg;

    logic signed [TW:0]       offset_hold_reg;
    logic                     valid_hold_reg;
    logic signed [VW-1:0]     value_hold_reg;
    logic                     last_hold_reg;
    logic                     close_reg;

    logic [TW-1:0]            mean_time_reg;
    logic                     res_valid_reg;
    logic [TW-1:0]            avg_time_reg;
    logic                     avg_valid_reg;
    logic signed [VW-1:0]     avg_value_reg;
    logic                     is_last_reg;

    logic                     accept;
    logic                     cfg_write;
    logic [TW-1:0]            base_time;
    logic [CNT_W-1:0]         count_inc;
    logic [EW-1:0]            eff_size;
    logic [EW-1:0]            gs_ext;
    logic                     out_free;

    logic signed [SUM_W-1:0]  div_dividend;
    logic [CNT_W-1:0]         div_divisor;
    logic                     div_done;
    logic signed [SUM_W-1:0]  div_quotient;

    assign accept    = smp_valid && smp_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !res_valid_reg || res_ready;
    assign pready    = 1'b1;
    assign prdata    = (paddr == tsad_pkg::ADDR_GROUP_SIZE)
                       ? tsad_pkg::DATA_W'(group_size_reg) : '0;

    always_comb
    begin
        base_time = (sample_count_reg == '0) ? sample_time : start_time_reg;
        count_inc = sample_count_reg + 1'b1;
        gs_ext    = EW'(group_size_reg);
        if (group_size_reg == '0)
        begin
            eff_size = EW'(1);
        end
        else if (gs_ext > EW'(MAX_GROUP))
        begin
            eff_size = EW'(MAX_GROUP);
        end
        else
        begin
            eff_size = gs_ext;
        end
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsad_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = tsad_pkg::ST_ACCUM;
                end
            end
            tsad_pkg::ST_ACCUM:
            begin
                if (last_hold_reg || (EW'(count_inc) >= eff_size))
                begin
                    state_next = tsad_pkg::ST_START_TIME;
                end
                else
                begin
                    state_next = tsad_pkg::ST_IDLE;
                end
            end
            tsad_pkg::ST_START_TIME:
            begin
                state_next = tsad_pkg::ST_WAIT_TIME;
            end
            tsad_pkg::ST_WAIT_TIME:
            begin
                if (div_done)
                begin
                    state_next = (valid_count_reg == '0) ? tsad_pkg::ST_EMIT
                                                         : tsad_pkg::ST_START_VALUE;
                end
            end
            tsad_pkg::ST_START_VALUE:
            begin
                state_next = tsad_pkg::ST_WAIT_VALUE;
            end
            tsad_pkg::ST_WAIT_VALUE:
            begin
                if (div_done)
                begin
                    state_next = tsad_pkg::ST_EMIT;
                end
            end
            tsad_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = tsad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsad_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        smp_ready          = 1'b0;
        div_ctrl.start     = 1'b0;
        div_ctrl.sel_value = 1'b0;
        case (state_reg)
            tsad_pkg::ST_IDLE:
            begin
                smp_ready = 1'b1;
            end
            tsad_pkg::ST_START_TIME:
            begin
                div_ctrl.start = 1'b1;
            end
            tsad_pkg::ST_START_VALUE:
            begin
                div_ctrl.start     = 1'b1;
                div_ctrl.sel_value = 1'b1;
            end
            default:
            begin
                smp_ready = 1'b0;
            end
        endcase
    end

    assign div_dividend = div_ctrl.sel_value ? value_sum_reg : offset_sum_reg;
    assign div_divisor  = div_ctrl.sel_value ? valid_count_reg : sample_count_reg;

    tsad_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctrl.start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tsad_pkg::ST_IDLE;
            group_size_reg   <= tsad_pkg::GSIZE_RESET;
            start_time_reg   <= '0;
            offset_sum_reg   <= '0;
            value_sum_reg    <= '0;
            valid_count_reg  <= '0;
            sample_count_reg <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && paddr == tsad_pkg::ADDR_GROUP_SIZE)
            begin
                group_size_reg <= pwdata[GW-1:0];
            end
            if (accept)
            begin
                start_time_reg <= base_time;
            end
            if (state_reg == tsad_pkg::ST_ACCUM)
            begin
                offset_sum_reg   <= offset_sum_reg + SUM_W'(offset_hold_reg);
                sample_count_reg <= count_inc;
                if (valid_hold_reg)
                begin
                    value_sum_reg   <= value_sum_reg + SUM_W'(value_hold_reg);
                    valid_count_reg <= valid_count_reg + 1'b1;
                end
            end
            if (state_reg == tsad_pkg::ST_EMIT && out_free)
            begin
                start_time_reg   <= '0;
                offset_sum_reg   <= '0;
                value_sum_reg    <= '0;
                valid_count_reg  <= '0;
                sample_count_reg <= '0;
                res_valid_reg    <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            offset_hold_reg <= $signed({1'b0, sample_time}) - $signed({1'b0, base_time});
            valid_hold_reg  <= sample_valid;
            value_hold_reg  <= sample_value;
            last_hold_reg   <= end_of_range;
        end
        if (state_reg == tsad_pkg::ST_ACCUM)
        begin
            close_reg <= last_hold_reg || (EW'(count_inc) >= eff_size);
        end
        if (state_reg == tsad_pkg::ST_WAIT_TIME && div_done)
        begin
            mean_time_reg <= start_time_reg + div_quotient[TW-1:0];
        end
        if (state_reg == tsad_pkg::ST_EMIT && out_free)
        begin
            avg_time_reg  <= mean_time_reg;
            avg_valid_reg <= (valid_count_reg != '0);
            avg_value_reg <= (valid_count_reg != '0) ? div_quotient[VW-1:0] : '0;
            is_last_reg   <= last_hold_reg && close_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign avg_time  = avg_time_reg;
    assign avg_valid = avg_valid_reg;
    assign avg_value = avg_value_reg;
    assign is_last   = is_last_reg;

endmodule

// File: hdl/tsad_checker.sv
// Port-level checks for the averaging decimator and the bind that attaches them.
module tsad_sva (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                pready,
    input logic                                smp_valid,
    input logic                                smp_ready,
    input logic                                res_valid,
    input logic                                res_ready,
    input logic [tsad_pkg::TIME_W-1:0]         avg_time,
    input logic                                avg_valid,
    input logic signed [tsad_pkg::VALUE_W-1:0] avg_value,
    input logic                                is_last
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && smp_ready |=> !smp_ready)
        else $error("smp_ready high in the cycle after a word was taken");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!smp_ready))
        else $error("result word appeared without a busy cycle before it");

    a_empty_group_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !avg_valid |-> avg_value == '0)
        else $error("nonzero avg_value on a group with no valid sample");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(avg_time) && $stable(avg_value)
            && $stable(avg_valid) && $stable(is_last))
        else $error("stalled result word changed");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind time_series_average_decimator tsad_sva u_tsad_sva (.*);

// File: bench/tsad_checker.sv
// Checker for the averaging decimator: tracks config writes, predicts result words, compares them.
module tsad_checker #(
    parameter int MAX_GROUP = tsad_pkg::DEF_MAX_GROUP
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [tsad_pkg::ADDR_W-1:0]         paddr,
    input  logic [tsad_pkg::DATA_W-1:0]         pwdata,
    input  logic                                smp_valid,
    input  logic                                smp_ready,
    input  logic [tsad_pkg::TIME_W-1:0]         sample_time,
    input  logic                                sample_valid,
    input  logic signed [tsad_pkg::VALUE_W-1:0] sample_value,
    input  logic                                end_of_range,
    input  logic                                res_valid,
    input  logic                                res_ready,
    input  logic [tsad_pkg::TIME_W-1:0]         avg_time,
    input  logic                                avg_valid,
    input  logic signed [tsad_pkg::VALUE_W-1:0] avg_value,
    input  logic                                is_last,
    output int                                  fail_count,
    output int                                  pending
);

    typedef struct packed {
        logic [tsad_pkg::TIME_W-1:0]  at;
        logic                         ok;
        logic [tsad_pkg::VALUE_W-1:0] av;
        logic                         fin;
    } avg_word_t;

    avg_word_t                    avg_q[$];
    logic [tsad_pkg::GSIZE_W-1:0] gsize;
    logic [tsad_pkg::TIME_W-1:0]  grp_start;
    longint                       off_sum;
    longint                       val_sum;
    int unsigned                  n_valid;
    int unsigned                  n_samples;
    int                           errors;

    function automatic int unsigned eff_size(input logic [tsad_pkg::GSIZE_W-1:0] g);
        if (g == 0)
            return 1;
        if (g > MAX_GROUP)
            return MAX_GROUP;
        return g;
    endfunction

    task automatic clear_group();
        grp_start = '0;
        off_sum   = 0;
        val_sum   = 0;
        n_valid   = 0;
        n_samples = 0;
    endtask

    task automatic fold_sample(input logic [tsad_pkg::TIME_W-1:0] t, input logic ok,
                               input logic signed [tsad_pkg::VALUE_W-1:0] v,
                               input logic fin);
        longint    mean_off;
        longint    mean_val;
        avg_word_t w;
        if (n_samples == 0)
            grp_start = t;
        off_sum += $signed({16'b0, t}) - $signed({16'b0, grp_start});
        if (ok)
        begin
            val_sum += longint'(v);
            n_valid++;
        end
        n_samples++;
        if (n_samples >= eff_size(gsize) || fin)
        begin
            mean_off = off_sum / longint'(n_samples);
            w.at     = grp_start + mean_off[tsad_pkg::TIME_W-1:0];
            w.ok     = (n_valid != 0);
            w.av     = '0;
            if (n_valid != 0)
            begin
                mean_val = val_sum / longint'(n_valid);
                w.av     = mean_val[tsad_pkg::VALUE_W-1:0];
            end
            w.fin = fin;
            avg_q = {avg_q, w};
            clear_group();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        avg_word_t w;
        if (!rst_n)
        begin
            gsize = tsad_pkg::GSIZE_RESET;
            clear_group();
            avg_q.delete();
            errors = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (avg_q.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, got time %0h valid %0b %s",
                             $time, avg_time, avg_valid, "value/last follow");
                    $display("%0t: unexpected word: value %0h last %0b",
                             $time, avg_value, is_last);
                    errors++;
                end
                else
                begin
                    w = avg_q.pop_front();
                    check_field("avg_time", 64'(w.at), 64'(avg_time));
                    check_field("avg_valid", 64'(w.ok), 64'(avg_valid));
                    check_field("avg_value", 64'(w.av), 64'($unsigned(avg_value)));
                    check_field("is_last", 64'(w.fin), 64'(is_last));
                end
            end
            if (smp_valid && smp_ready)
                fold_sample(sample_time, sample_valid, sample_value, end_of_range);
            if (psel && penable && pwrite && pready && paddr == tsad_pkg::ADDR_GROUP_SIZE)
                gsize = pwdata[tsad_pkg::GSIZE_W-1:0];
            fail_count <= errors;
            pending    <= avg_q.size();
        end
    end

endmodule

// File: bench/tb.sv
// Testbench top for the averaging decimator: clock, reset, config writes, sample stimulus, verdict.
module tb;

    logic                                clk;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [tsad_pkg::ADDR_W-1:0]         paddr;
    logic [tsad_pkg::DATA_W-1:0]         pwdata;
    logic [tsad_pkg::DATA_W-1:0]         prdata;
    logic                                pready;
    logic                                smp_valid;
    logic                                smp_ready;
    logic [tsad_pkg::TIME_W-1:0]         sample_time;
    logic                                sample_valid;
    logic signed [tsad_pkg::VALUE_W-1:0] sample_value;
    logic                                end_of_range;
    logic                                res_valid;
    logic                                res_ready;
    logic [tsad_pkg::TIME_W-1:0]         avg_time;
    logic                                avg_valid;
    logic signed [tsad_pkg::VALUE_W-1:0] avg_value;
    logic                                is_last;
    int                                  fail_count;
    int                                  pending;

    logic [tsad_pkg::TIME_W-1:0]         clock_ms;
    bit                                  sender_busy;
    bit                                  hold_req;
    int                                  burst_left;

    time_series_average_decimator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .smp_valid    (smp_valid),
        .smp_ready    (smp_ready),
        .sample_time  (sample_time),
        .sample_valid (sample_valid),
        .sample_value (sample_value),
        .end_of_range (end_of_range),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .avg_time     (avg_time),
        .avg_valid    (avg_valid),
        .avg_value    (avg_value),
        .is_last      (is_last)
    );

    tsad_checker CHK (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .smp_valid    (smp_valid),
        .smp_ready    (smp_ready),
        .sample_time  (sample_time),
        .sample_valid (sample_valid),
        .sample_value (sample_value),
        .end_of_range (end_of_range),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .avg_time     (avg_time),
        .avg_valid    (avg_valid),
        .avg_value    (avg_value),
        .is_last      (is_last),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #2 clk = ~clk;

    initial
    begin
        #8000000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic logic [tsad_pkg::TIME_W-1:0] rand_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            clock_ms = clock_ms + $urandom_range(1, 1000);
        else if (r < 80)
            clock_ms = clock_ms - $urandom_range(0, 500);
        else if (r >= 90)
            clock_ms = tsad_pkg::TIME_W'({$urandom, $urandom});
        return clock_ms;
    endfunction

    function automatic logic signed [tsad_pkg::VALUE_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom;
        else if (r < 70)
            return $signed($urandom_range(0, 200)) - 100;
        else if (r < 80)
            return 32'h7FFF_FFFF;
        else if (r < 90)
            return 32'h8000_0000;
        return 0;
    endfunction

    task automatic send_item(input logic [tsad_pkg::TIME_W-1:0] t, input logic ok,
                             input logic signed [tsad_pkg::VALUE_W-1:0] v, input logic fin);
        sample_time  <= t;
        sample_valid <= ok;
        sample_value <= v;
        end_of_range <= fin;
        smp_valid    <= 1'b1;
        sender_busy = 1;
        @(posedge clk);
        while (!smp_ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            smp_valid <= 1'b0;
            sender_busy = 0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
                                                       $urandom_range(0, 8);
        end
    endtask

    task automatic drain();
        if (sender_busy)
        begin
            smp_valid <= 1'b0;
            sender_busy = 0;
        end
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    task automatic set_group_size(input logic [tsad_pkg::GSIZE_W-1:0] size);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tsad_pkg::ADDR_GROUP_SIZE;
        pwdata  <= tsad_pkg::DATA_W'(size);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random stall modes, plus a long hold-off on each request
    initial
    begin : receiver
        int mode;
        int mode_left;
        int k;
        mode      = 0;
        mode_left = 0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_ready <= 1'b0;
                hold_req = 0;
                for (k = 0; k < 400; k++)
                    @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       res_ready <= 1'b1;
                    1:       res_ready <= ($urandom_range(0, 1) == 1);
                    default: res_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        int                           items_left;
        int                           n;
        int                           pick;
        int                           phase;
        int                           eor_odds;
        logic [tsad_pkg::GSIZE_W-1:0] gsz;
        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        smp_valid    = 1'b0;
        sample_time  = '0;
        sample_valid = 1'b0;
        sample_value = '0;
        end_of_range = 1'b0;
        res_ready    = 1'b0;
        clock_ms     = '0;
        sender_busy  = 0;
        hold_req     = 0;
        burst_left   = 0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset group size of one: extremes of time and value, an invalid sample
        send_item(48'h0, 1'b1, 32'h7FFF_FFFF, 1'b0);
        send_item(48'hFFFF_FFFF_FFFF, 1'b1, 32'h8000_0000, 1'b1);
        send_item(48'd5, 1'b0, 32'h1234_5678, 1'b0);

        set_group_size(11'd0);
        send_item(48'd100, 1'b1, -32'sd1, 1'b0);

        // time going backwards, sums past 32 bits
        set_group_size(11'd4);
        send_item(48'd1000, 1'b1, 32'h7FFF_FFFF, 1'b0);
        send_item(48'd990, 1'b1, 32'h7FFF_FFFF, 1'b0);
        send_item(48'd1003, 1'b0, 32'h8000_0000, 1'b0);
        send_item(48'd985, 1'b1, 32'h7FFF_FFFF, 1'b0);
        send_item(48'hFFFF_FFFF_FFF0, 1'b1, 32'h8000_0000, 1'b0);
        send_item(48'h0000_0000_0003, 1'b1, 32'h8000_0000, 1'b0);
        send_item(48'hFFFF_FFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0);
        send_item(48'h8000_0000_0000, 1'b1, 32'h8000_0001, 1'b0);

        // early flush by end of range
        set_group_size(11'd3);
        send_item(48'd7, 1'b1, -32'sd7, 1'b1);
        send_item(48'd10, 1'b1, -32'sd3, 1'b0);
        send_item(48'd11, 1'b1, -32'sd4, 1'b1);

        // size shrinks below the count of an open group
        send_item(48'd20, 1'b0, 32'h0, 1'b0);
        send_item(48'd21, 1'b1, 32'sd9, 1'b0);
        set_group_size(11'd2);
        send_item(48'd30, 1'b1, -32'sd2, 1'b0);

        // oversize saturates
        set_group_size(11'd2047);
        send_item(48'd40, 1'b1, 32'sd5, 1'b0);
        send_item(48'd45, 1'b0, 32'sd6, 1'b1);
        set_group_size(11'd1024);
        send_item(48'd50, 1'b0, 32'sd1, 1'b0);
        send_item(48'd49, 1'b0, 32'sd2, 1'b1);

        items_left = 1330;
        phase      = 0;
        while (items_left > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                gsz = tsad_pkg::GSIZE_W'($urandom_range(1, 8));
            else if (pick < 75)
                gsz = tsad_pkg::GSIZE_W'($urandom_range(9, 64));
            else if (pick < 83)
                gsz = '0;
            else if (pick < 90)
                gsz = tsad_pkg::GSIZE_W'(1024);
            else if (pick < 95)
                gsz = tsad_pkg::GSIZE_W'(1023);
            else
                gsz = tsad_pkg::GSIZE_W'($urandom_range(1025, 2047));
            if (phase % 8 == 1)
                gsz = tsad_pkg::GSIZE_W'(1);
            set_group_size(gsz);
            if (phase % 8 == 1)
                hold_req = 1;
            eor_odds = (gsz <= 64) ? 25 : 12;
            n = $urandom_range(15, 70);
            repeat (n)
                send_item(rand_time(), $urandom_range(0, 3) != 0, rand_value(),
                          $urandom_range(0, eor_odds - 1) == 0);
            items_left -= n;
            phase++;
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
